@@ design/qfrti_pkg.sv @@
// Package: shared constants and types for the binary128 round-to-integral block.
package qfrti_pkg;
    localparam int unsigned WordW = 64;
    localparam logic [14:0] ExpMax  = 15'h7fff;
    localparam logic [14:0] ExpBias = 15'h3fff;
    localparam logic [14:0] ExpInt  = 15'h406f;

    typedef enum logic [1:0] {
        RM_NEAREST = 2'd0,
        RM_ZERO    = 2'd1,
        RM_UP      = 2'd2,
        RM_DOWN    = 2'd3
    } t_rmode;

    typedef struct packed {
        logic [WordW-1:0] value_hi;
        logic [WordW-1:0] value_lo;
    } t_in_beat;

    typedef struct packed {
        logic [WordW-1:0] result_hi;
        logic [WordW-1:0] result_lo;
        logic             invalid;
    } t_out_beat;
endpackage

@@ design/qfrti_if.sv @@
// Interfaces: valid/ready channels for operands, results and configuration.
interface qfrti_in_if;
    import qfrti_pkg::*;
    logic     valid;
    logic     ready;
    t_in_beat payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface qfrti_out_if;
    import qfrti_pkg::*;
    logic      valid;
    logic      ready;
    t_out_beat payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface qfrti_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/quad_float_round_to_integral.sv @@
// Top level: binary128 round to integral value, four-stage pipeline.
// Usage:
//   i_op  carries one binary128 operand per beat (value_hi, value_lo).
//   o_res carries result_hi, result_lo and the invalid flag per beat.
//   i_cfg writes the 2-bit rounding mode (0 nearest even, 1 toward zero,
//   2 toward +inf, 3 toward -inf); write only while the pipe is empty.
// Pipeline: an operand beat passes four register stages (classify, mask
//   build, masking/round decision, increment) on the way to its result.
// Throughput: one beat per cycle while o_res.ready keeps the pipe moving.
// Stall: when o_res.ready is low the pipe holds; a stage accepts new data
//   whenever the stage after it is free or moving, so a bubble fills.
// Reset: valid bits clear and the rounding mode returns to nearest even.
//   Configuration is always accepted (ready tied high).
// Signaling NaN is quieted and flags invalid; inexact is never raised.
module quad_float_round_to_integral
    import qfrti_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    qfrti_cfg_if.sink    i_cfg,
    qfrti_in_if.sink     i_op,
    qfrti_out_if.source  o_res
);
    // Rounding mode register
    t_rmode r_mode;
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= RM_NEAREST;
        end else if (i_cfg.valid) begin
            r_mode <= t_rmode'(i_cfg.data);
        end
    end

    // Stage valid bits and advance enables
    logic r_v1, r_v2, r_v3, r_v4;
    logic adv1, adv2, adv3, adv4;
    assign adv4 = !r_v4 || o_res.ready;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign i_op.ready = adv1;

    // Stage 1: classify
    logic [127:0] r1_val;
    logic         r1_pass, r1_small, r1_up, r1_near, r1_half, r1_inv;
    logic [6:0]   r1_j;   // fraction bits to clear, 1..112
    logic [63:0]  hi_in, lo_in;
    logic [14:0]  e_in;
    logic [1:0]   rm_eff;
    logic         is_snan;
    logic [14:0]  j_full;
    assign hi_in = i_op.payload.value_hi;
    assign lo_in = i_op.payload.value_lo;
    assign e_in  = hi_in[62:48];
    assign is_snan = (e_in == ExpMax) && ((|hi_in[47:0]) || (|lo_in)) && !hi_in[47];
    assign rm_eff = hi_in[63] ? (r_mode ^ {1'b0, r_mode[1]}) : r_mode;
    assign j_full = ExpInt - e_in;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv1) begin
            r_v1 <= i_op.valid;
        end
        if (adv1) begin
            r1_val   <= {hi_in | {16'd0, is_snan, 47'd0}, lo_in};
            r1_pass  <= (e_in >= ExpInt) ||
                        (((hi_in & 64'h7fffffffffffffff) | lo_in) == 64'd0);
            r1_small <= e_in < ExpBias;
            r1_up    <= rm_eff == RM_UP;
            r1_near  <= rm_eff == RM_NEAREST;
            r1_half  <= (e_in == ExpBias - 15'd1) && ((|hi_in[47:0]) || (|lo_in));
            r1_j     <= j_full[6:0];
            r1_inv   <= is_snan;
        end
    end

    // Stage 2: build the masks for the cleared bits and the round bit
    logic [127:0] r2_val, r2_keep, r2_rpos;
    logic         r2_pass, r2_small, r2_up, r2_near, r2_half, r2_inv;
    logic [127:0] ones_j;
    assign ones_j = ~(~128'd0 << r1_j);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv2) begin
            r_v2 <= r_v1;
        end
        if (adv2) begin
            r2_val   <= r1_val;
            r2_keep  <= ~ones_j;
            r2_rpos  <= 128'd1 << (r1_j - 7'd1);
            r2_pass  <= r1_pass;
            r2_small <= r1_small;
            r2_up    <= r1_up;
            r2_near  <= r1_near;
            r2_half  <= r1_half;
            r2_inv   <= r1_inv;
        end
    end

    // Stage 3: mask, round and sticky bits, increment decision
    logic [127:0] r3_val, r3_inc;
    logic         r3_do_inc, r3_inv;
    logic         rbit, sticky, lsb, inc_dec;
    logic [127:0] masked;
    assign rbit   = |(r2_val & r2_rpos);
    assign sticky = |(r2_val & ~r2_keep & ~r2_rpos);
    assign masked = r2_val & r2_keep;
    assign lsb    = |(r2_val & {r2_rpos[126:0], 1'b0});
    assign inc_dec = (rbit || sticky) &&
                     (r2_up || (r2_near && rbit && (sticky || lsb)));
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv3) begin
            r_v3 <= r_v2;
        end
        if (adv3) begin
            r3_inv    <= r2_inv;
            r3_inc    <= {r2_rpos[126:0], 1'b0};
            r3_do_inc <= 1'b0;
            if (r2_pass) begin
                r3_val <= r2_val;
            end else if (r2_small) begin
                r3_val <= {r2_val[127], ((r2_up || (r2_near && r2_half)) ? ExpBias : 15'd0),
                           112'd0};
            end else if (rbit || sticky) begin
                r3_val    <= masked;
                r3_do_inc <= inc_dec;
            end else begin
                r3_val <= r2_val;
            end
        end
    end

    // Stage 4: increment with carry into the exponent
    logic [127:0] r4_val;
    logic         r4_inv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (adv4) begin
            r_v4 <= r_v3;
        end
        if (adv4) begin
            r4_val <= r3_do_inc ? r3_val + r3_inc : r3_val;
            r4_inv <= r3_inv;
        end
    end

    assign o_res.valid             = r_v4;
    assign o_res.payload.result_hi = r4_val[127:64];
    assign o_res.payload.result_lo = r4_val[63:0];
    assign o_res.payload.invalid   = r4_inv;

    // Checks
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> o_res.valid && $stable(r4_val))
        else $error("result changed under stall");
    a_inv_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.payload.invalid |-> r4_val[126:112] == ExpMax && r4_val[111])
        else $error("invalid without quiet NaN");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && adv4 |=> r_v4)
        else $error("stage 3 beat lost");
endmodule
